[sv/multichannel_soft_uart_line_rx_macros.svh]
// assertion helpers, included by the merge stage (msur_merge)
`ifndef MULTICHANNEL_SOFT_UART_LINE_RX_MACROS_SVH
`define MULTICHANNEL_SOFT_UART_LINE_RX_MACROS_SVH

// same-cycle implication, checked out of reset
`define MSUR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MSUR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/msur_pkg.sv]
package msur_pkg;

    localparam int CHANNELS_DEF      = 4;
    localparam int TX_RING_DEPTH_DEF = 64;
    localparam int LINE_MAX_DEF      = 64;

    localparam logic [7:0] BIT_TICKS_RST = 8'd3;
    localparam logic [3:0] FRAME_BITS    = 4'd9;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ENQUEUE = 2'd1,
        OP_RELEASE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_TX_LINES = 2'd0,
        KIND_RX_BYTE  = 2'd1,
        KIND_ENQ_STAT = 2'd2
    } kind_t;

    // per-lane command strobes, valid for one accepted request
    typedef struct packed {
        logic tick;
        logic enq;
        logic rel;
    } lane_cmd_t;

    // what a receive lane stores on the current tick
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [5:0] pos;
        logic       done;
    } rx_res_t;

endpackage

[sv/msur_rx_lane.sv]
module msur_rx_lane
    import msur_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  lane_cmd_t  cmd,
    input  logic       rx_level,
    input  logic [7:0] bit_ticks,
    output rx_res_t    res
);

    localparam int LEN_W = $clog2(LINE_MAX + 1);

    logic             busy_reg, busy_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [3:0]       bits_reg, bits_next;
    logic [7:0]       shift_reg, shift_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic [3:0]       bits_dec;
    logic             take;
    logic             drop_ws;
    logic             store;
    logic [LEN_W-1:0] len_inc;
    logic [LEN_W+5:0] pos_wide;

    always_comb begin
        bits_dec = bits_reg - 4'd1;
        take     = busy_reg && (cnt_reg == 8'd0) && (bits_dec == 4'd0);
        drop_ws  = (len_reg == '0) &&
                   (shift_reg == CHAR_SPACE || shift_reg == CHAR_CR || shift_reg == CHAR_LF);
        store    = take && !drop_ws && (len_reg < LEN_W'(LINE_MAX));
        len_inc  = len_reg + LEN_W'(1);
        pos_wide = {6'd0, len_reg};

        res.valid = store;
        res.data  = shift_reg;
        res.pos   = pos_wide[5:0];
        res.done  = (len_inc >= LEN_W'(LINE_MAX)) || (shift_reg == CHAR_LF);
    end

    always_comb begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        len_next   = len_reg;
        if (cmd.rel) begin
            len_next = '0;
        end
        if (cmd.tick) begin
            if (busy_reg) begin
                if (cnt_reg == 8'd0) begin
                    cnt_next  = bit_ticks - 8'd1;
                    bits_next = bits_dec;
                    if (bits_dec == 4'd0) begin
                        busy_next = 1'b0;
                        if (store) begin
                            len_next = len_inc;
                        end
                    end else begin
                        shift_next = {rx_level, shift_reg[7:1]};
                    end
                end else begin
                    cnt_next = cnt_reg - 8'd1;
                end
            end else if (!rx_level) begin
                busy_next  = 1'b1;
                cnt_next   = bit_ticks;
                bits_next  = FRAME_BITS;
                shift_next = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= 8'd0;
            bits_reg  <= 4'd0;
            shift_reg <= 8'd0;
            len_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            len_reg   <= len_next;
        end
    end

endmodule

[sv/msur_tx_lane.sv]
module msur_tx_lane
    import msur_pkg::*;
#(
    parameter int TX_RING_DEPTH = TX_RING_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  lane_cmd_t  cmd,
    input  logic [7:0] tx_byte,
    input  logic [7:0] bit_ticks,
    output logic       tx_level,
    output logic       ring_full
);

    localparam int AW = $clog2(TX_RING_DEPTH);
    localparam int FW = $clog2(TX_RING_DEPTH + 1);

    logic [7:0] ring_mem [TX_RING_DEPTH];
    logic [7:0] rd_data_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          busy_reg, busy_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [3:0]    bits_reg, bits_next;
    logic [7:0]    shift_reg, shift_next;
    logic [7:0]    hold_reg, hold_next;
    logic          level_reg, level_next;

    logic          wr_en;
    logic          load;
    logic          busy_run;
    logic [7:0]    cnt_dec;
    logic [3:0]    bits_dec;

    assign ring_full = (fill_reg == FW'(TX_RING_DEPTH));
    assign wr_en     = cmd.enq && !ring_full;
    // level after the current tick, sampled when the request is taken
    assign tx_level  = level_next;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        hold_next  = hold_reg;
        level_next = level_reg;
        load       = 1'b0;
        busy_run   = busy_reg;
        cnt_dec    = cnt_reg - 8'd1;
        bits_dec   = bits_reg - 4'd1;

        if (wr_en) begin
            head_next = (head_reg == AW'(TX_RING_DEPTH - 1)) ? '0 : head_reg + AW'(1);
            fill_next = fill_reg + FW'(1);
        end

        if (cmd.tick) begin
            load = !busy_reg && (fill_reg != '0);
            if (load) begin
                hold_next = rd_data_reg;
                tail_next = (tail_reg == AW'(TX_RING_DEPTH - 1)) ? '0 : tail_reg + AW'(1);
                fill_next = fill_reg - FW'(1);
                busy_run  = 1'b1;
            end
            busy_next = busy_run;
            if (busy_run) begin
                cnt_next = cnt_dec;
                if (cnt_dec == 8'd0) begin
                    cnt_next = bit_ticks;
                    if (bits_reg == 4'd0) begin
                        level_next = 1'b0;
                        shift_next = hold_next;
                        bits_next  = FRAME_BITS;
                    end else begin
                        bits_next = bits_dec;
                        if (bits_dec == 4'd0) begin
                            level_next = 1'b1;
                            busy_next  = 1'b0;
                        end else begin
                            level_next = shift_reg[0];
                            shift_next = {1'b0, shift_reg[7:1]};
                        end
                    end
                end
            end
        end
    end

    // ring storage, read data prefetched at the next tail
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[head_reg] <= tx_byte;
        end
        if (wr_en && (head_reg == tail_next)) begin
            rd_data_reg <= tx_byte;
        end else begin
            rd_data_reg <= ring_mem[tail_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            busy_reg  <= 1'b0;
            cnt_reg   <= BIT_TICKS_RST;
            bits_reg  <= 4'd0;
            shift_reg <= 8'd0;
            hold_reg  <= 8'd0;
            level_reg <= 1'b1;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            hold_reg  <= hold_next;
            level_reg <= level_next;
        end
    end

endmodule

[sv/msur_merge.sv]
`include "multichannel_soft_uart_line_rx_macros.svh"

module msur_merge
    import msur_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  opcode_t    opcode,
    input  rx_res_t    rx_res [CHANNELS],
    input  logic [7:0] tx_lines,
    input  logic [2:0] enq_channel,
    input  logic       enq_full,
    input  logic       m_ready,
    output logic       busy,
    output logic       m_valid,
    output kind_t      m_kind,
    output logic [7:0] m_tx_lines,
    output logic [2:0] m_channel,
    output logic [7:0] m_byte,
    output logic [5:0] m_pos,
    output logic       m_done,
    output logic       m_full,
    output logic       m_last
);

    logic [CHANNELS-1:0] pend_reg, pend_next;
    logic [7:0]          byte_reg [CHANNELS];
    logic [5:0]          pos_reg  [CHANNELS];
    logic [CHANNELS-1:0] done_reg;
    logic                fin_reg, fin_next;
    kind_t               fin_kind_reg;
    logic [7:0]          fin_txl_reg;
    logic [2:0]          fin_ch_reg;
    logic                fin_full_reg;

    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [7:0]          out_txl_reg;
    logic [2:0]          out_ch_reg;
    logic [7:0]          out_byte_reg;
    logic [5:0]          out_pos_reg;
    logic                out_done_reg;
    logic                out_full_reg;
    logic                out_last_reg;

    logic [CHANNELS-1:0] first_oh;
    logic [2:0]          sel_ch;
    logic [7:0]          sel_byte;
    logic [5:0]          sel_pos;
    logic                sel_done;
    logic                emit;

    assign busy = (|pend_reg) || fin_reg;
    assign emit = busy && (!out_valid_reg || m_ready);

    // lowest pending lane goes first
    always_comb begin
        first_oh = pend_reg & (~pend_reg + CHANNELS'(1));
        sel_ch   = 3'd0;
        sel_byte = 8'd0;
        sel_pos  = 6'd0;
        sel_done = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (first_oh[i]) begin
                sel_ch   = sel_ch | 3'(i);
                sel_byte = sel_byte | byte_reg[i];
                sel_pos  = sel_pos | pos_reg[i];
                sel_done = sel_done | done_reg[i];
            end
        end
    end

    always_comb begin
        pend_next = pend_reg;
        fin_next  = fin_reg;
        if (emit) begin
            if (|pend_reg) begin
                pend_next = pend_reg & ~first_oh;
            end else begin
                fin_next = 1'b0;
            end
        end
        if (accept) begin
            fin_next = (opcode == OP_TICK) || (opcode == OP_ENQUEUE);
            for (int i = 0; i < CHANNELS; i++) begin
                pend_next[i] = (opcode == OP_TICK) && rx_res[i].valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < CHANNELS; i++) begin
                byte_reg[i] <= rx_res[i].data;
                pos_reg[i]  <= rx_res[i].pos;
                done_reg[i] <= rx_res[i].done;
            end
            fin_kind_reg <= (opcode == OP_TICK) ? KIND_TX_LINES : KIND_ENQ_STAT;
            fin_txl_reg  <= (opcode == OP_TICK) ? tx_lines : 8'd0;
            fin_ch_reg   <= (opcode == OP_TICK) ? 3'd0 : enq_channel;
            fin_full_reg <= (opcode == OP_ENQUEUE) && enq_full;
        end
        if (emit) begin
            if (|pend_reg) begin
                out_kind_reg <= KIND_RX_BYTE;
                out_txl_reg  <= 8'd0;
                out_ch_reg   <= sel_ch;
                out_byte_reg <= sel_byte;
                out_pos_reg  <= sel_pos;
                out_done_reg <= sel_done;
                out_full_reg <= 1'b0;
                out_last_reg <= 1'b0;
            end else begin
                out_kind_reg <= fin_kind_reg;
                out_txl_reg  <= fin_txl_reg;
                out_ch_reg   <= fin_ch_reg;
                out_byte_reg <= 8'd0;
                out_pos_reg  <= 6'd0;
                out_done_reg <= 1'b0;
                out_full_reg <= fin_full_reg;
                out_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            fin_reg  <= fin_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_kind     = out_kind_reg;
    assign m_tx_lines = out_txl_reg;
    assign m_channel  = out_ch_reg;
    assign m_byte     = out_byte_reg;
    assign m_pos      = out_pos_reg;
    assign m_done     = out_done_reg;
    assign m_full     = out_full_reg;
    assign m_last     = out_last_reg;

    `MSUR_ASSERT_NEXT(a_tick_busy, aclk, aresetn, accept && (opcode == OP_TICK), fin_reg, "tick lost its final result")
    `MSUR_ASSERT_NOW(a_pend_has_fin, aclk, aresetn, |pend_reg, fin_reg, "byte results without final result")
    `MSUR_ASSERT_NOW(a_rx_not_last, aclk, aresetn, out_valid_reg && (out_kind_reg == KIND_RX_BYTE), !out_last_reg, "received byte marked last")
    `MSUR_ASSERT_NOW(a_no_accept_busy, aclk, aresetn, accept, !(|pend_reg) && !fin_reg, "request taken while merge busy")

endmodule

[sv/multichannel_soft_uart_line_rx.sv]
// flow: a request is taken while s_tready is high and registered into the merge stage, whose
// results pass through the output register, one result per cycle while m_tready is high
// a tick yields its stored bytes and then the tx_lines result, an enqueue one status, a release none;
// a new request is taken only once the merge stage has emitted every result of the last one
// reset: aresetn synchronous active low, clears lanes, ring pointers, merge and bit_ticks (3)
module multichannel_soft_uart_line_rx
    import msur_pkg::*;
#(
    parameter int CHANNELS      = CHANNELS_DEF,
    parameter int TX_RING_DEPTH = TX_RING_DEPTH_DEF,
    parameter int LINE_MAX      = LINE_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: bit_ticks
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rx_lines[7:0], channel[10:8], tx_byte[18:11], zero pad
    input  logic [1:0]  s_tuser,   // opcode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_lines[7:0], rx_channel[10:8], rx_byte[18:11],
                                   // position[24:19], line_done[25], queue_full[26], zero pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // last result of the request
);

    // oversampling factor; the user must write it only while idle, the block does not enforce it
    logic [7:0] bit_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg <= BIT_TICKS_RST;
        end else if (cfg_wr_en) begin
            bit_ticks_reg <= cfg_wr_data;
        end
    end

    // request decode
    logic       accept;
    opcode_t    opcode;
    logic [7:0] rx_lines;
    logic [2:0] channel;
    logic [7:0] tx_byte;
    logic       merge_busy;

    assign s_tready = !merge_busy;
    assign accept   = s_tvalid && s_tready;
    assign opcode   = opcode_t'(s_tuser);
    assign rx_lines = s_tdata[7:0];
    assign channel  = s_tdata[10:8];
    assign tx_byte  = s_tdata[18:11];

    // lanes, one receiver and one transmitter per channel
    lane_cmd_t           lane_cmd [CHANNELS];
    rx_res_t             rx_res   [CHANNELS];
    logic [CHANNELS-1:0] tx_level;
    logic [CHANNELS-1:0] ring_full;
    logic [CHANNELS-1:0] chan_sel;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        // channel addresses of CHANNELS and above never match, so they are refused or ignored
        assign chan_sel[i]      = (channel == 3'(i));
        assign lane_cmd[i].tick = accept && (opcode == OP_TICK);
        assign lane_cmd[i].enq  = accept && (opcode == OP_ENQUEUE) && chan_sel[i];
        assign lane_cmd[i].rel  = accept && (opcode == OP_RELEASE) && chan_sel[i];

        msur_rx_lane #(
            .LINE_MAX (LINE_MAX)
        ) u_rx (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (lane_cmd[i]),
            .rx_level  (rx_lines[i]),
            .bit_ticks (bit_ticks_reg),
            .res       (rx_res[i])
        );

        msur_tx_lane #(
            .TX_RING_DEPTH (TX_RING_DEPTH)
        ) u_tx (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (lane_cmd[i]),
            .tx_byte   (tx_byte),
            .bit_ticks (bit_ticks_reg),
            .tx_level  (tx_level[i]),
            .ring_full (ring_full[i])
        );
    end

    // transmit levels after this tick, unused channels read 0
    logic [7:0] tx_lines;
    always_comb begin
        tx_lines = 8'd0;
        for (int i = 0; i < CHANNELS; i++) begin
            tx_lines[i] = tx_level[i];
        end
    end

    // refused unless an in-range channel has room
    logic enq_full;
    assign enq_full = !(|(chan_sel & ~ring_full));

    // merge stage and output register
    kind_t      m_kind;
    logic [7:0] m_tx_lines;
    logic [2:0] m_channel;
    logic [7:0] m_byte;
    logic [5:0] m_pos;
    logic       m_done;
    logic       m_full;

    msur_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .opcode      (opcode),
        .rx_res      (rx_res),
        .tx_lines    (tx_lines),
        .enq_channel (channel),
        .enq_full    (enq_full),
        .m_ready     (m_tready),
        .busy        (merge_busy),
        .m_valid     (m_tvalid),
        .m_kind      (m_kind),
        .m_tx_lines  (m_tx_lines),
        .m_channel   (m_channel),
        .m_byte      (m_byte),
        .m_pos       (m_pos),
        .m_done      (m_done),
        .m_full      (m_full),
        .m_last      (m_tlast)
    );

    assign m_tuser = m_kind;
    assign m_tdata = {5'd0, m_full, m_done, m_pos, m_byte, m_channel, m_tx_lines};

endmodule
